### rtl/core/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, ignored while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/kesm_pkg.sv
// types and constants shared by the edge set merge block
package kesm_pkg;

    localparam int CELL_W  = 12;
    localparam int CFG_W   = 13;
    localparam int LABEL_W = CELL_W;
    localparam int WORD_W  = LABEL_W + 1;

    localparam logic [CFG_W-1:0] CELL_COUNT_RESET = 13'd4096;

    typedef enum logic [1:0] {
        KIND_EDGE   = 2'd0,
        KIND_IGNORE = 2'd1,
        KIND_FINISH = 2'd2
    } item_kind_t;

    typedef struct packed {
        item_kind_t          kind;
        logic [CELL_W-1:0]   cell_a;
        logic [CELL_W-1:0]   cell_b;
    } work_item_t;

    typedef struct packed {
        logic       valid;
        work_item_t item;
    } queue_head_t;

    typedef struct packed {
        logic              path_opened;
        logic              first_cell_visited;
        logic              finished;
        logic [CELL_W-1:0] edge_first;
        logic [CELL_W-1:0] edge_second;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR   = 3'd0,
        ST_IDLE    = 3'd1,
        ST_READ_B  = 3'd2,
        ST_DECIDE  = 3'd3,
        ST_WRITE_B = 3'd4,
        ST_WALK    = 3'd5,
        ST_RESULT  = 3'd6
    } back_state_t;

endpackage

### rtl/core/kesm_ram.sv
// generic simple dual-port ram with registered read
module kesm_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

### rtl/core/kesm_front.sv
// front end: takes input words, classifies them and queues them for the back end
module kesm_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         enable,
    input  logic [kesm_pkg::CFG_W-1:0]   limit,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         operation,
    input  logic [kesm_pkg::CELL_W-1:0]  cell_a,
    input  logic [kesm_pkg::CELL_W-1:0]  cell_b,
    output kesm_pkg::queue_head_t        head,
    input  logic                         pop
);
    import kesm_pkg::*;

    work_item_t item_in;
    work_item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop_ok;

    // out-of-range edges are marked here so the back end skips the ram
    always_comb
    begin
        item_in.cell_a = cell_a;
        item_in.cell_b = cell_b;
        if (operation)
        begin
            item_in.kind = KIND_FINISH;
        end
        else if (({1'b0, cell_a} < limit) && ({1'b0, cell_b} < limit))
        begin
            item_in.kind = KIND_EDGE;
        end
        else
        begin
            item_in.kind = KIND_IGNORE;
        end
    end

    assign in_ready   = enable && (count_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];
    assign pop_ok     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = push   ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_ok ? ~rd_ptr_reg : rd_ptr_reg;
        case ({push, pop_ok})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

### rtl/core/kesm_back.sv
// back end: label ram sequencer for joins, relabel walk and clearing pass
module kesm_back #(
    parameter int MAX_CELLS = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [kesm_pkg::CFG_W-1:0]   limit,
    input  kesm_pkg::queue_head_t        head,
    output logic                         pop,
    output logic                         init_done,
    output logic                         out_valid,
    input  logic                         out_ready,
    output kesm_pkg::result_t            result
);
    import kesm_pkg::*;

    localparam int AW      = $clog2(MAX_CELLS);
    localparam int CNT_RAW = $clog2(MAX_CELLS + 1);
    localparam int CNT_W   = (CNT_RAW > CFG_W) ? CNT_RAW : CFG_W;

    back_state_t       state_reg, state_next;
    work_item_t        item_reg, item_next;
    logic [WORD_W-1:0] word_a_reg, word_a_next;
    logic [LABEL_W-1:0] keep_reg, keep_next;
    logic [LABEL_W-1:0] gone_reg, gone_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic              report_reg, report_next;
    logic              opened_reg, opened_next;
    logic              visited_reg, visited_next;
    logic              init_done_reg, init_done_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [WORD_W-1:0] wr_data, rd_data;

    logic [CNT_W-1:0]  head_a_ext, a_ext, b_ext;
    logic              a_in, b_in;
    logic [LABEL_W-1:0] a_label, b_label;
    logic              walk_issue;
    logic              clear_last;
    logic              out_free;

    kesm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_CELLS)
    ) u_label_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ram word: membership flag on top, set label below
    assign head_a_ext = CNT_W'(head.item.cell_a);
    assign a_ext      = CNT_W'(item_reg.cell_a);
    assign b_ext      = CNT_W'(item_reg.cell_b);
    assign a_in       = word_a_reg[WORD_W-1];
    assign a_label    = word_a_reg[LABEL_W-1:0];
    assign b_in       = rd_data[WORD_W-1];
    assign b_label    = rd_data[LABEL_W-1:0];
    assign walk_issue = (idx_reg < CNT_W'(limit));
    assign clear_last = (idx_reg == CNT_W'(MAX_CELLS - 1));
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = report_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    unique case (head.item.kind)
                        KIND_EDGE:   state_next = ST_READ_B;
                        KIND_FINISH: state_next = ST_CLEAR;
                        default:     state_next = ST_RESULT;
                    endcase
                end
            end
            ST_READ_B:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!a_in && !b_in)
                begin
                    state_next = ST_WRITE_B;
                end
                else if (a_in && b_in && (a_label != b_label))
                begin
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_WRITE_B:
            begin
                state_next = ST_RESULT;
            end
            ST_WALK:
            begin
                if (!walk_issue && !pend_reg)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_next      = item_reg;
        word_a_next    = word_a_reg;
        keep_next      = keep_reg;
        gone_next      = gone_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        report_next    = report_reg;
        opened_next    = opened_reg;
        visited_next   = visited_reg;
        init_done_next = init_done_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pop            = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[AW-1:0];
                wr_data  = '0;
                idx_next = idx_reg + CNT_W'(1);
                if (clear_last)
                begin
                    init_done_next = 1'b1;
                end
            end
            ST_IDLE:
            begin
                pop = head.valid;
                if (head.valid)
                begin
                    item_next    = head.item;
                    opened_next  = 1'b0;
                    visited_next = 1'b0;
                    idx_next     = '0;
                    report_next  = (head.item.kind == KIND_FINISH);
                    rd_en        = (head.item.kind == KIND_EDGE);
                    rd_addr      = head_a_ext[AW-1:0];
                end
            end
            ST_READ_B:
            begin
                rd_en       = 1'b1;
                rd_addr     = b_ext[AW-1:0];
                word_a_next = rd_data;
            end
            ST_DECIDE:
            begin
                if (!a_in && !b_in)
                begin
                    // both new: a starts a set under its own index
                    wr_en        = 1'b1;
                    wr_addr      = a_ext[AW-1:0];
                    wr_data      = {1'b1, item_reg.cell_a};
                    opened_next  = 1'b1;
                    visited_next = 1'b1;
                end
                else if (!a_in)
                begin
                    wr_en       = 1'b1;
                    wr_addr     = a_ext[AW-1:0];
                    wr_data     = {1'b1, b_label};
                    opened_next = 1'b1;
                end
                else if (!b_in)
                begin
                    wr_en       = 1'b1;
                    wr_addr     = b_ext[AW-1:0];
                    wr_data     = {1'b1, a_label};
                    opened_next = 1'b1;
                end
                else if (a_label != b_label)
                begin
                    keep_next   = a_label;
                    gone_next   = b_label;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    opened_next = 1'b1;
                end
            end
            ST_WRITE_B:
            begin
                wr_en   = 1'b1;
                wr_addr = b_ext[AW-1:0];
                wr_data = {1'b1, item_reg.cell_a};
            end
            ST_WALK:
            begin
                // read one entry a cycle, rewrite the previous one if it carries the old label
                rd_en          = walk_issue;
                rd_addr        = idx_reg[AW-1:0];
                pend_next      = walk_issue;
                pend_addr_next = idx_reg[AW-1:0];
                if (walk_issue)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (pend_reg && b_in && (b_label == gone_reg))
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_addr_reg;
                    wr_data = {1'b1, keep_reg};
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_next.path_opened        = opened_reg;
                    out_next.first_cell_visited = visited_reg;
                    out_next.finished           = report_reg;
                    out_next.edge_first         = opened_reg ? item_reg.cell_a : '0;
                    out_next.edge_second        = opened_reg ? item_reg.cell_b : '0;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            report_reg    <= 1'b0;
            init_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            report_reg    <= report_next;
            init_done_reg <= init_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        word_a_reg    <= word_a_next;
        keep_reg      <= keep_next;
        gone_reg      <= gone_next;
        pend_addr_reg <= pend_addr_next;
        opened_reg    <= opened_next;
        visited_reg   <= visited_next;
        out_reg       <= out_next;
    end

    assign init_done = init_done_reg;
    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

### rtl/core/kruskal_edge_set_merge.sv
// edge set merge: an accepted edge word reads the labels of a and b, decides and registers a result;
// when both cells are new, the label of b is written in an extra step before the result
// a merge adds a relabel walk over the label ram entries below limit, one entry read per cycle
// finish clears every membership flag, one ram entry per cycle; cell_count resets to 4096
// the back end holds one word at a time and pops the next once its result is registered, and a
// two-word queue lets the input side run ahead; after reset a clearing pass runs with in_ready low
module kruskal_edge_set_merge #(
    parameter int MAX_CELLS = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [kesm_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         operation,
    input  logic [kesm_pkg::CELL_W-1:0]  cell_a,
    input  logic [kesm_pkg::CELL_W-1:0]  cell_b,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         path_opened,
    output logic                         first_cell_visited,
    output logic                         finished,
    output logic [kesm_pkg::CELL_W-1:0]  edge_first,
    output logic [kesm_pkg::CELL_W-1:0]  edge_second
);
    import kesm_pkg::*;

    localparam int CNT_RAW = $clog2(MAX_CELLS + 1);
    localparam int LIM_W   = (CNT_RAW > CFG_W) ? CNT_RAW : CFG_W;

    logic [CFG_W-1:0] cell_count_reg, cell_count_next;
    logic [CFG_W-1:0] limit;
    queue_head_t      head;
    logic             pop;
    logic             init_done;
    result_t          result;

    assign cfg_ready       = 1'b1;
    assign cell_count_next = (cfg_valid && cfg_ready) ? cfg_data : cell_count_reg;

    // counts above the ram depth act as the full depth
    assign limit = (LIM_W'(cell_count_reg) < LIM_W'(MAX_CELLS)) ? cell_count_reg
                                                               : CFG_W'(MAX_CELLS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_count_reg <= CELL_COUNT_RESET;
        end
        else
        begin
            cell_count_reg <= cell_count_next;
        end
    end

    kesm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (init_done),
        .limit     (limit),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .cell_a    (cell_a),
        .cell_b    (cell_b),
        .head      (head),
        .pop       (pop)
    );

    kesm_back #(
        .MAX_CELLS (MAX_CELLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit),
        .head      (head),
        .pop       (pop),
        .init_done (init_done),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign path_opened        = result.path_opened;
    assign first_cell_visited = result.first_cell_visited;
    assign finished           = result.finished;
    assign edge_first         = result.edge_first;
    assign edge_second        = result.edge_second;

endmodule

### rtl/core/kesm_checker.sv
// port-level checks for the edge set merge block, bound to the top level
`include "assert_macros.svh"

module kesm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         path_opened,
    input logic                         first_cell_visited,
    input logic                         finished,
    input logic [kesm_pkg::CELL_W-1:0]  edge_first,
    input logic [kesm_pkg::CELL_W-1:0]  edge_second
);

    // a stalled result word holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(edge_first) && $stable(edge_second) && $stable(path_opened) && $stable(finished))

    // edge echo only for an opened path
    `ASSERT_IMPLIES(a_echo_zero, clk, rst_n, out_valid && !path_opened, edge_first == '0 && edge_second == '0)

    // a new pair always opens its edge
    `ASSERT_IMPLIES(a_visit_opens, clk, rst_n, out_valid && first_cell_visited, path_opened)

    // finish word carries nothing else
    `ASSERT_IMPLIES(a_finish_alone, clk, rst_n, out_valid && finished, !path_opened && !first_cell_visited)

endmodule

bind kruskal_edge_set_merge kesm_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .path_opened        (path_opened),
    .first_cell_visited (first_cell_visited),
    .finished           (finished),
    .edge_first         (edge_first),
    .edge_second        (edge_second)
);
